[rtl/core/sts_pkg.sv]
// shared types, constants and codes of the stereo transient shaper
package sts_pkg;

   localparam int STS_SAMPLE_BITS = 24;
   localparam int STS_COEF_BITS   = 24;

   localparam int ENV_BITS       = 32;
   localparam int TRANS_BITS     = ENV_BITS + 1;
   localparam int GAIN_BITS      = 32;
   localparam int FACTOR_BITS    = 28;
   localparam int MUL_BITS       = 33;
   localparam int PROD_BITS      = 2 * MUL_BITS;
   localparam int AMOUNT_BITS    = 16;
   localparam int COEF_MAX_BITS  = 32;
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 32;

   // 0.001 and 0.01 in Q1.31, 1.6 in Q.23, unity gain in Q.24
   localparam int THR_LOW       = 2147484;
   localparam int THR_HIGH      = 21474836;
   localparam int SUS_NEG_SCALE = 13421773;
   localparam int UNITY         = 16777216;

   localparam logic [AMOUNT_BITS-1:0]   OUT_GAIN_RESET  = 16'd16384;
   localparam logic [COEF_MAX_BITS-1:0] FAST_RISE_RESET = 32'd13622026;
   localparam logic [COEF_MAX_BITS-1:0] FAST_FALL_RESET = 32'd16707456;
   localparam logic [COEF_MAX_BITS-1:0] SLOW_RISE_RESET = 32'd16759749;
   localparam logic [COEF_MAX_BITS-1:0] SLOW_FALL_RESET = 32'd16775469;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_ATTACK    = 3'd0,
      CSR_SUSTAIN   = 3'd1,
      CSR_OUT_GAIN  = 3'd2,
      CSR_FAST_RISE = 3'd3,
      CSR_FAST_FALL = 3'd4,
      CSR_SLOW_RISE = 3'd5,
      CSR_SLOW_FALL = 3'd6
   } csr_index_type;

   typedef struct packed {
      logic signed [AMOUNT_BITS-1:0] attack;
      logic signed [AMOUNT_BITS-1:0] sustain;
      logic [AMOUNT_BITS-1:0]        out_gain;
      logic [COEF_MAX_BITS-1:0]      fast_rise;
      logic [COEF_MAX_BITS-1:0]      fast_fall;
      logic [COEF_MAX_BITS-1:0]      slow_rise;
      logic [COEF_MAX_BITS-1:0]      slow_fall;
   } cfg_type;

   // operand pair loaded into the shared multiplier
   typedef enum logic [3:0] {
      MUL_NONE,
      MUL_FAST,
      MUL_SLOW,
      MUL_SUS_K,
      MUL_ATTACK,
      MUL_SUS_GAIN,
      MUL_OUT_GAIN,
      MUL_LEFT,
      MUL_RIGHT
   } mul_op_type;

   // register update taken from the input samples, the held product or the envelopes
   typedef enum logic [3:0] {
      WB_NONE,
      WB_LOAD,
      WB_DIFF,
      WB_FAST,
      WB_SLOW,
      WB_TRANS,
      WB_FACTOR,
      WB_ATTACK,
      WB_SUSTAIN,
      WB_GAIN,
      WB_LEFT,
      WB_OUT
   } wb_op_type;

   typedef struct packed {
      mul_op_type mul_op;
      wb_op_type  wb_op;
   } cmd_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DIFF,
      ST_FAST,
      ST_SLOW,
      ST_SUS_K,
      ST_TRANS,
      ST_ATTACK,
      ST_ATTACK_ADD,
      ST_SUS_MUL,
      ST_SUS_APPLY,
      ST_GAIN_MUL,
      ST_GAIN_RND,
      ST_LEFT,
      ST_RIGHT,
      ST_FINISH
   } state_type;

endpackage

[rtl/core/sts_if.sv]
// stream and register write channels of the stereo transient shaper
interface sts_req_if import sts_pkg::*; #(parameter int SAMPLE_BITS = STS_SAMPLE_BITS);
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] left_sample;
   logic signed [SAMPLE_BITS-1:0] right_sample;
   modport source (output valid, left_sample, right_sample, input ready);
   modport sink (input valid, left_sample, right_sample, output ready);
endinterface

interface sts_rsp_if import sts_pkg::*; #(parameter int SAMPLE_BITS = STS_SAMPLE_BITS);
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] left_result;
   logic signed [SAMPLE_BITS-1:0] right_result;
   modport source (output valid, left_result, right_result, input ready);
   modport sink (input valid, left_result, right_result, output ready);
endinterface

interface sts_csr_if import sts_pkg::*;;
   logic                      valid;
   logic                      ready;
   logic [CSR_INDEX_BITS-1:0] index;
   logic [CSR_DATA_BITS-1:0]  data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

[rtl/core/sts_csr.sv]
// configuration register file of the stereo transient shaper
module sts_csr import sts_pkg::*; #(
   parameter int COEF_BITS = STS_COEF_BITS
) (
   input  logic    clock,
   input  logic    reset,
   sts_csr_if.sink csr_write,
   output cfg_type cfg
);

   localparam cfg_type CFG_RESET = '{
      attack:    '0,
      sustain:   '0,
      out_gain:  OUT_GAIN_RESET,
      fast_rise: COEF_MAX_BITS'(FAST_RISE_RESET[COEF_BITS-1:0]),
      fast_fall: COEF_MAX_BITS'(FAST_FALL_RESET[COEF_BITS-1:0]),
      slow_rise: COEF_MAX_BITS'(SLOW_RISE_RESET[COEF_BITS-1:0]),
      slow_fall: COEF_MAX_BITS'(SLOW_FALL_RESET[COEF_BITS-1:0])
   };

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_write.ready = 1'b1;
   assign cfg             = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write.valid) begin
         case (csr_write.index)
            CSR_ATTACK:    cfg_in.attack    = csr_write.data[AMOUNT_BITS-1:0];
            CSR_SUSTAIN:   cfg_in.sustain   = csr_write.data[AMOUNT_BITS-1:0];
            CSR_OUT_GAIN:  cfg_in.out_gain  = csr_write.data[AMOUNT_BITS-1:0];
            CSR_FAST_RISE: cfg_in.fast_rise = COEF_MAX_BITS'(csr_write.data[COEF_BITS-1:0]);
            CSR_FAST_FALL: cfg_in.fast_fall = COEF_MAX_BITS'(csr_write.data[COEF_BITS-1:0]);
            CSR_SLOW_RISE: cfg_in.slow_rise = COEF_MAX_BITS'(csr_write.data[COEF_BITS-1:0]);
            CSR_SLOW_FALL: cfg_in.slow_fall = COEF_MAX_BITS'(csr_write.data[COEF_BITS-1:0]);
            default: ;  // unmapped index, beat dropped
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

[rtl/core/sts_ctrl.sv]
// sequencer that steps one sample pair through the shared multiplier
module sts_ctrl import sts_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output cmd_type cmd
);

   state_type state_ff;
   state_type state_in;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd.mul_op   = MUL_NONE;
      cmd.wb_op    = WB_NONE;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.wb_op = WB_LOAD;
               state_in  = ST_DIFF;
            end
         end
         ST_DIFF: begin
            cmd.wb_op = WB_DIFF;
            state_in  = ST_FAST;
         end
         ST_FAST: begin
            cmd.mul_op = MUL_FAST;
            state_in   = ST_SLOW;
         end
         ST_SLOW: begin
            cmd.mul_op = MUL_SLOW;
            cmd.wb_op  = WB_FAST;
            state_in   = ST_SUS_K;
         end
         ST_SUS_K: begin
            cmd.mul_op = MUL_SUS_K;
            cmd.wb_op  = WB_SLOW;
            state_in   = ST_TRANS;
         end
         ST_TRANS: begin
            cmd.wb_op = WB_TRANS;
            state_in  = ST_ATTACK;
         end
         ST_ATTACK: begin
            cmd.mul_op = MUL_ATTACK;
            cmd.wb_op  = WB_FACTOR;
            state_in   = ST_ATTACK_ADD;
         end
         ST_ATTACK_ADD: begin
            cmd.wb_op = WB_ATTACK;
            state_in  = ST_SUS_MUL;
         end
         ST_SUS_MUL: begin
            cmd.mul_op = MUL_SUS_GAIN;
            state_in   = ST_SUS_APPLY;
         end
         ST_SUS_APPLY: begin
            cmd.wb_op = WB_SUSTAIN;
            state_in  = ST_GAIN_MUL;
         end
         ST_GAIN_MUL: begin
            cmd.mul_op = MUL_OUT_GAIN;
            state_in   = ST_GAIN_RND;
         end
         ST_GAIN_RND: begin
            cmd.wb_op = WB_GAIN;
            state_in  = ST_LEFT;
         end
         ST_LEFT: begin
            cmd.mul_op = MUL_LEFT;
            state_in   = ST_RIGHT;
         end
         ST_RIGHT: begin
            cmd.mul_op = MUL_RIGHT;
            cmd.wb_op  = WB_LEFT;
            state_in   = ST_FINISH;
         end
         ST_FINISH: begin
            // wait here while the previous result beat is still pending
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.wb_op    = WB_OUT;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

[rtl/core/sts_dpath.sv]
// envelope followers, gain computation and output scaling on one shared multiplier
module sts_dpath import sts_pkg::*; #(
   parameter int SAMPLE_BITS = STS_SAMPLE_BITS,
   parameter int COEF_BITS   = STS_COEF_BITS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  cmd_type                       cmd,
   input  cfg_type                       cfg,
   input  logic signed [SAMPLE_BITS-1:0] left_sample,
   input  logic signed [SAMPLE_BITS-1:0] right_sample,
   output logic signed [SAMPLE_BITS-1:0] left_result,
   output logic signed [SAMPLE_BITS-1:0] right_result
);

   localparam logic signed [PROD_BITS-1:0] RES_MAX =
      (PROD_BITS'(1) <<< (SAMPLE_BITS - 1)) - PROD_BITS'(1);
   localparam logic signed [PROD_BITS-1:0] RES_MIN = -RES_MAX - PROD_BITS'(1);

   // round half up, i.e. floor((x + 2^(s-1)) / 2^s)
   function automatic logic signed [PROD_BITS-1:0] rnd_shift(
      input logic signed [PROD_BITS-1:0] x,
      input int                          s
   );
      return (x + (PROD_BITS'(1) <<< (s - 1))) >>> s;
   endfunction

   function automatic logic signed [SAMPLE_BITS-1:0] saturate(
      input logic signed [PROD_BITS-1:0] x
   );
      logic signed [PROD_BITS-1:0] y;
      y = x;
      if (x > RES_MAX) y = RES_MAX;
      if (x < RES_MIN) y = RES_MIN;
      return SAMPLE_BITS'(y);
   endfunction

   logic signed [SAMPLE_BITS-1:0] left_ff, left_in;
   logic signed [SAMPLE_BITS-1:0] right_ff, right_in;
   logic [ENV_BITS-1:0]           peak_ff, peak_in;
   logic [ENV_BITS-1:0]           fast_env_ff, fast_env_in;
   logic [ENV_BITS-1:0]           slow_env_ff, slow_env_in;
   logic [ENV_BITS-1:0]           fast_dist_ff, fast_dist_in;
   logic [ENV_BITS-1:0]           slow_dist_ff, slow_dist_in;
   logic                          fast_up_ff, fast_up_in;
   logic                          slow_up_ff, slow_up_in;
   logic signed [TRANS_BITS-1:0]  trans_ff, trans_in;
   logic signed [GAIN_BITS-1:0]   gain_ff, gain_in;
   logic signed [FACTOR_BITS-1:0] factor_ff, factor_in;
   logic [GAIN_BITS-1:0]          scale_ff, scale_in;
   logic signed [PROD_BITS-1:0]   prod_ff, prod_in;
   logic signed [SAMPLE_BITS-1:0] left_keep_ff, left_keep_in;
   logic signed [SAMPLE_BITS-1:0] left_res_ff, left_res_in;
   logic signed [SAMPLE_BITS-1:0] right_res_ff, right_res_in;

   logic [SAMPLE_BITS-1:0]        left_abs;
   logic [SAMPLE_BITS-1:0]        right_abs;
   logic signed [MUL_BITS-1:0]    mul_a;
   logic signed [MUL_BITS-1:0]    mul_b;
   logic signed [PROD_BITS-1:0]   mul_p;
   logic [PROD_BITS-1:0]          fol_sum;
   logic [ENV_BITS-1:0]           fol_q;
   logic signed [PROD_BITS-1:0]   att_ten;
   logic signed [GAIN_BITS-1:0]   gain_pos;

   assign left_result  = left_res_ff;
   assign right_result = right_res_ff;

   // most negative sample maps to exactly 1.0
   assign left_abs  = left_sample[SAMPLE_BITS-1] ? $unsigned(-left_sample) : $unsigned(left_sample);
   assign right_abs = right_sample[SAMPLE_BITS-1] ? $unsigned(-right_sample) : $unsigned(right_sample);

   assign fol_sum  = $unsigned(prod_ff) + (PROD_BITS'(1'b1) << (COEF_BITS - 1));
   assign fol_q    = ENV_BITS'(fol_sum >> COEF_BITS);
   assign att_ten  = (prod_ff <<< 3) + (prod_ff <<< 1);
   assign gain_pos = gain_ff[GAIN_BITS-1] ? '0 : gain_ff;

   always_comb begin
      case (cmd.mul_op)
         MUL_FAST: begin
            mul_a = $signed(MUL_BITS'(fast_up_ff ? cfg.fast_rise : cfg.fast_fall));
            mul_b = $signed(MUL_BITS'(fast_dist_ff));
         end
         MUL_SLOW: begin
            mul_a = $signed(MUL_BITS'(slow_up_ff ? cfg.slow_rise : cfg.slow_fall));
            mul_b = $signed(MUL_BITS'(slow_dist_ff));
         end
         MUL_SUS_K: begin
            mul_a = MUL_BITS'(cfg.sustain);
            mul_b = MUL_BITS'(SUS_NEG_SCALE);
         end
         MUL_ATTACK: begin
            mul_a = MUL_BITS'(cfg.attack);
            mul_b = MUL_BITS'(trans_ff);
         end
         MUL_SUS_GAIN: begin
            mul_a = MUL_BITS'(gain_ff);
            mul_b = MUL_BITS'(factor_ff);
         end
         MUL_OUT_GAIN: begin
            mul_a = $signed(MUL_BITS'(cfg.out_gain));
            mul_b = MUL_BITS'(gain_pos);
         end
         MUL_LEFT: begin
            mul_a = MUL_BITS'(left_ff);
            mul_b = $signed(MUL_BITS'(scale_ff));
         end
         MUL_RIGHT: begin
            mul_a = MUL_BITS'(right_ff);
            mul_b = $signed(MUL_BITS'(scale_ff));
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign mul_p = mul_a * mul_b;

   always_comb begin
      left_in      = left_ff;
      right_in     = right_ff;
      peak_in      = peak_ff;
      fast_env_in  = fast_env_ff;
      slow_env_in  = slow_env_ff;
      fast_dist_in = fast_dist_ff;
      slow_dist_in = slow_dist_ff;
      fast_up_in   = fast_up_ff;
      slow_up_in   = slow_up_ff;
      trans_in     = trans_ff;
      gain_in      = gain_ff;
      factor_in    = factor_ff;
      scale_in     = scale_ff;
      left_keep_in = left_keep_ff;
      left_res_in  = left_res_ff;
      right_res_in = right_res_ff;
      prod_in      = (cmd.mul_op == MUL_NONE) ? prod_ff : mul_p;

      case (cmd.wb_op)
         WB_LOAD: begin
            left_in  = left_sample;
            right_in = right_sample;
            peak_in  = ENV_BITS'((left_abs > right_abs) ? left_abs : right_abs)
                       << (ENV_BITS - SAMPLE_BITS);
         end
         WB_DIFF: begin
            // a tie picks the fall coefficient and leaves the envelope at the peak
            fast_up_in   = peak_ff > fast_env_ff;
            slow_up_in   = peak_ff > slow_env_ff;
            fast_dist_in = (peak_ff > fast_env_ff) ? peak_ff - fast_env_ff
                                                   : fast_env_ff - peak_ff;
            slow_dist_in = (peak_ff > slow_env_ff) ? peak_ff - slow_env_ff
                                                   : slow_env_ff - peak_ff;
         end
         WB_FAST: begin
            fast_env_in = fast_up_ff ? peak_ff - fol_q : peak_ff + fol_q;
         end
         WB_SLOW: begin
            slow_env_in = slow_up_ff ? peak_ff - fol_q : peak_ff + fol_q;
         end
         WB_TRANS: begin
            trans_in = $signed({1'b0, fast_env_ff}) - $signed({1'b0, slow_env_ff});
            gain_in  = GAIN_BITS'(UNITY);
         end
         WB_FACTOR: begin
            // 1 + 1.6 * sustain in Q.24
            factor_in = FACTOR_BITS'(rnd_shift(prod_ff, 13) + PROD_BITS'(UNITY));
         end
         WB_ATTACK: begin
            if (trans_ff > TRANS_BITS'(THR_LOW)) begin
               gain_in = gain_ff + GAIN_BITS'(rnd_shift(att_ten, 21));
            end
         end
         WB_SUSTAIN: begin
            if (slow_env_ff > ENV_BITS'(THR_LOW) && trans_ff < TRANS_BITS'(THR_HIGH)) begin
               if (cfg.sustain > 0) begin
                  gain_in = gain_ff + (GAIN_BITS'(cfg.sustain) <<< 10);
               end else begin
                  gain_in = GAIN_BITS'(rnd_shift(prod_ff, 24));
               end
            end
         end
         WB_GAIN: begin
            scale_in = GAIN_BITS'(rnd_shift(prod_ff, 14));
         end
         WB_LEFT: begin
            left_keep_in = saturate(rnd_shift(prod_ff, 24));
         end
         WB_OUT: begin
            left_res_in  = left_keep_ff;
            right_res_in = saturate(rnd_shift(prod_ff, 24));
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fast_env_ff <= '0;
         slow_env_ff <= '0;
      end else begin
         fast_env_ff <= fast_env_in;
         slow_env_ff <= slow_env_in;
      end
   end

   always_ff @(posedge clock) begin
      left_ff      <= left_in;
      right_ff     <= right_in;
      peak_ff      <= peak_in;
      fast_dist_ff <= fast_dist_in;
      slow_dist_ff <= slow_dist_in;
      fast_up_ff   <= fast_up_in;
      slow_up_ff   <= slow_up_in;
      trans_ff     <= trans_in;
      gain_ff      <= gain_in;
      factor_ff    <= factor_in;
      scale_ff     <= scale_in;
      prod_ff      <= prod_in;
      left_keep_ff <= left_keep_in;
      left_res_ff  <= left_res_in;
      right_res_ff <= right_res_in;
   end

endmodule

[rtl/core/stereo_transient_shaper.sv]
// Stereo transient shaper: each request beat carries one signed stereo sample pair and
// yields one response beat with both channels scaled by a common gain. The gain comes from
// a fast and a slow envelope follower on the peak of the pair: their difference drives the
// attack shaping, the slow level with a small difference drives the sustain shaping, and
// the result is clamped at zero and scaled by the output gain. All eight products of a pair
// run in order through one registered 33 x 33 bit multiplier, so the next request beat is
// taken once a pair ends its steps, the last waiting on any pending response; a finished
// pair waits in the output register and the next request beat is taken meanwhile. Registers
// by index: 0 attack amount, 1 sustain amount, 2 output gain, 3 and 4 fast rise and fall
// coefficients, 5 and 6 slow rise and fall coefficients; write them only while idle.
module stereo_transient_shaper import sts_pkg::*; #(
   parameter int SAMPLE_BITS = STS_SAMPLE_BITS,
   parameter int COEF_BITS   = STS_COEF_BITS
) (
   input  logic      clock,
   input  logic      reset,
   sts_req_if.sink   req_stream,
   sts_rsp_if.source rsp_stream,
   sts_csr_if.sink   csr_write
);

   cfg_type cfg;
   cmd_type cmd;

   sts_csr #(
      .COEF_BITS (COEF_BITS)
   ) u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .cfg       (cfg)
   );

   sts_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_stream.valid),
      .req_ready (req_stream.ready),
      .rsp_valid (rsp_stream.valid),
      .rsp_ready (rsp_stream.ready),
      .cmd       (cmd)
   );

   sts_dpath #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .COEF_BITS   (COEF_BITS)
   ) u_dpath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .cfg          (cfg),
      .left_sample  (req_stream.left_sample),
      .right_sample (req_stream.right_sample),
      .left_result  (rsp_stream.left_result),
      .right_result (rsp_stream.right_result)
   );

   // one pair in flight: no second request beat right after one is taken
   ap_single_pair: assert property (@(posedge clock) disable iff (reset)
      (req_stream.valid && req_stream.ready) |=> !req_stream.ready)
      else $error("request taken twice in a row");

   // a taken request beat starts the envelope distance step
   ap_start_seq: assert property (@(posedge clock) disable iff (reset)
      (req_stream.valid && req_stream.ready) |=> (cmd.wb_op == WB_DIFF))
      else $error("sequence did not start after request beat");

   // the multiplier is only busy while no request can be taken
   ap_mul_busy: assert property (@(posedge clock) disable iff (reset)
      (cmd.mul_op != MUL_NONE) |-> !req_stream.ready)
      else $error("multiplier active while idle");

endmodule
